### src/prrs_pkg.sv
`timescale 1ns / 1ps

package prrs_pkg;

   localparam int PRRS_NUM_TASKS  = 64;
   localparam int PRRS_NUM_LEVELS = 4;

   localparam int ACTION_W  = 2;
   localparam int TASK_ID_W = 6;
   localparam int PRIO_W    = 2;
   localparam int TICK_W    = 32;

   localparam logic [ACTION_W-1:0] ACT_ADD      = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_REMOVE   = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_SCHEDULE = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_TICK     = 2'd3;

endpackage

### src/priority_round_robin_scheduler.sv
`timescale 1ns / 1ps

// Task scheduler with one FIFO ready queue per priority level, kept as doubly
// linked lists in a single task record memory with one port. A command word is
// taken when start is high and busy is low; its result passes through the
// evaluate state and the rsp_ registers, appears on the rsp_ ports for exactly
// one cycle, marked by rsp_valid, and cannot be held off. A good command keeps
// busy high through evaluation and four write slots, so no new word is taken
// until it is through: the task record is read as the word is taken, then it
// is evaluated, and the slots update the memory one entry a cycle. A rejected
// command (error set) frees the block after evaluation. After reset, busy
// stays high while the queued flags of the memory are cleared, one entry a cycle.
module priority_round_robin_scheduler
   import prrs_pkg::*;
#(
   parameter int NUM_TASKS  = PRRS_NUM_TASKS,
   parameter int NUM_LEVELS = PRRS_NUM_LEVELS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [ACTION_W-1:0]  req_action,
   input  logic [TASK_ID_W-1:0] req_task_id,
   input  logic [PRIO_W-1:0]    req_priority_req,
   output logic                 rsp_valid,
   output logic [TASK_ID_W-1:0] rsp_chosen_task,
   output logic                 rsp_chosen_valid,
   output logic [TASK_ID_W-1:0] rsp_previous_task,
   output logic                 rsp_previous_valid,
   output logic                 rsp_switch_needed,
   output logic                 rsp_needs_scheduling,
   output logic                 rsp_error,
   output logic [TICK_W-1:0]    rsp_tick_count
);

   localparam int TW  = $clog2(NUM_TASKS);
   localparam int LW  = $clog2(NUM_TASKS + 1);
   localparam int LVW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
   localparam int IDW = (TW > TASK_ID_W) ? TW : TASK_ID_W;
   localparam int PLW = (LVW > PRIO_W) ? LVW : PRIO_W;

   localparam logic [LW-1:0] NO_LINK = LW'(NUM_TASKS);
   localparam logic [TW-1:0] LAST_TASK = TW'(NUM_TASKS - 1);
   localparam logic [LVW-1:0] LAST_LEVEL = LVW'(NUM_LEVELS - 1);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_EVAL  = 2'd2;
   localparam logic [1:0] ST_WRITE = 2'd3;

   localparam logic [1:0] SLOT_PREV   = 2'd0;
   localparam logic [1:0] SLOT_NEXT_A = 2'd1;
   localparam logic [1:0] SLOT_NEXT_B = 2'd2;
   localparam logic [1:0] SLOT_REC    = 2'd3;

   typedef struct packed {
      logic           queued;
      logic [LVW-1:0] level;
      logic [LW-1:0]  next_link;
      logic [LW-1:0]  prev_link;
   } rec_type;

   rec_type rec_mem [NUM_TASKS];
   rec_type rd_ff;

   logic [1:0]            state_ff, state_in;
   logic [TW-1:0]         clr_ff, clr_in;
   logic [1:0]            slot_ff, slot_in;
   logic [TW-1:0]         head_ff [NUM_LEVELS];
   logic [TW-1:0]         head_in [NUM_LEVELS];
   logic [TW-1:0]         tail_ff [NUM_LEVELS];
   logic [TW-1:0]         tail_in [NUM_LEVELS];
   logic [NUM_LEVELS-1:0] nonempty_ff, nonempty_in;
   logic [TW-1:0]         rt_ff, rt_in;
   logic                  rv_ff, rv_in;
   logic                  rs_ff, rs_in;
   logic [TICK_W-1:0]     ticks_ff, ticks_in;
   logic                  resched_ff, resched_in;

   logic [ACTION_W-1:0]   act_ff, act_in;
   logic [TW-1:0]         t_ff, t_in;
   logic [LVW-1:0]        lv_ff, lv_in;
   logic                  ok_ff, ok_in;

   logic [3:0]            wen_ff, wen_in;
   logic [TW-1:0]         wad_ff [4];
   logic [TW-1:0]         wad_in [4];
   logic [LW-1:0]         wlk_ff [3];
   logic [LW-1:0]         wlk_in [3];
   rec_type               wrec_ff, wrec_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [TASK_ID_W-1:0]  chosen_ff, chosen_in;
   logic                  cvalid_ff, cvalid_in;
   logic [TASK_ID_W-1:0]  prev_ff, prev_in;
   logic                  pvalid_ff, pvalid_in;
   logic                  sw_ff, sw_in;
   logic                  needs_ff, needs_in;
   logic                  err_ff, err_in;
   logic [TICK_W-1:0]     count_ff, count_in;

   logic                  accept;
   logic [IDW-1:0]        id_wide;
   logic [TW-1:0]         id_ix;
   logic                  id_ok;
   logic [PLW-1:0]        pr_wide;
   logic [LVW-1:0]        pr_lv;
   logic                  found;
   logic [LVW-1:0]        found_lv;
   logic [TW-1:0]         sel_t;
   logic [LVW-1:0]        sel_lv;
   logic                  sel_ok;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   assign id_wide = IDW'(req_task_id);
   assign id_ix   = id_wide[TW-1:0];
   assign id_ok   = (32'(req_task_id) < 32'(NUM_TASKS));
   assign pr_wide = PLW'(req_priority_req);
   assign pr_lv   = (32'(req_priority_req) >= 32'(NUM_LEVELS)) ? LAST_LEVEL
                                                               : pr_wide[LVW-1:0];

   always_comb begin
      found    = 1'b0;
      found_lv = '0;
      for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
         if (nonempty_ff[i]) begin
            found    = 1'b1;
            found_lv = LVW'(i);
         end
      end
   end

   always_comb begin
      sel_t  = id_ix;
      sel_lv = pr_lv;
      sel_ok = id_ok;
      case (req_action)
         ACT_ADD: begin
            sel_t = id_ix;
         end
         ACT_REMOVE: begin
            sel_t = id_ix;
         end
         ACT_SCHEDULE: begin
            sel_t  = head_ff[found_lv];
            sel_lv = found_lv;
            sel_ok = found;
         end
         default: begin
            sel_t  = rt_ff;
            sel_ok = 1'b1;
         end
      endcase
   end

   always_comb begin
      logic [LW-1:0]  n, p, tl_link, t_link;
      logic           n_ok, p_ok, err, cond;
      logic [TW-1:0]  n_ix, p_ix, tl;
      logic [LVW-1:0] lv_e;
      logic [IDW-1:0] t_wide, rt_wide;

      state_in     = state_ff;
      clr_in       = clr_ff;
      slot_in      = slot_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      nonempty_in  = nonempty_ff;
      rt_in        = rt_ff;
      rv_in        = rv_ff;
      rs_in        = rs_ff;
      ticks_in     = ticks_ff;
      resched_in   = resched_ff;
      act_in       = act_ff;
      t_in         = t_ff;
      lv_in        = lv_ff;
      ok_in        = ok_ff;
      wen_in       = wen_ff;
      wad_in       = wad_ff;
      wlk_in       = wlk_ff;
      wrec_in      = wrec_ff;
      rsp_valid_in = 1'b0;
      chosen_in    = chosen_ff;
      cvalid_in    = cvalid_ff;
      prev_in      = prev_ff;
      pvalid_in    = pvalid_ff;
      sw_in        = sw_ff;
      needs_in     = needs_ff;
      err_in       = err_ff;
      count_in     = count_ff;

      n       = rd_ff.next_link;
      p       = rd_ff.prev_link;
      n_ok    = (n != NO_LINK);
      p_ok    = (p != NO_LINK);
      n_ix    = n[TW-1:0];
      p_ix    = p[TW-1:0];
      lv_e    = ((act_ff == ACT_REMOVE) || (act_ff == ACT_TICK)) ? rd_ff.level : lv_ff;
      tl      = tail_ff[lv_e];
      tl_link = LW'(tl);
      t_link  = LW'(t_ff);
      t_wide  = IDW'(t_ff);
      rt_wide = IDW'(rt_ff);
      err     = 1'b0;
      cond    = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + TW'(1);
            if (clr_ff == LAST_TASK) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EVAL;
               act_in   = req_action;
               t_in     = sel_t;
               lv_in    = sel_lv;
               ok_in    = sel_ok;
            end
         end
         ST_EVAL: begin
            rsp_valid_in = 1'b1;
            chosen_in    = '0;
            cvalid_in    = 1'b0;
            prev_in      = '0;
            pvalid_in    = 1'b0;
            sw_in        = 1'b0;
            wen_in       = '0;
            wad_in[SLOT_REC]  = t_ff;
            wrec_in.queued    = 1'b1;
            wrec_in.level     = lv_e;
            wrec_in.next_link = NO_LINK;
            wrec_in.prev_link = tl_link;
            case (act_ff)
               ACT_ADD: begin
                  err = !ok_ff || rd_ff.queued;
                  if (!err) begin
                     wen_in[SLOT_NEXT_A] = nonempty_ff[lv_e];
                     wad_in[SLOT_NEXT_A] = tl;
                     wlk_in[SLOT_NEXT_A] = t_link;
                     wen_in[SLOT_REC]    = 1'b1;
                     if (!nonempty_ff[lv_e]) begin
                        wrec_in.prev_link = NO_LINK;
                        head_in[lv_e]     = t_ff;
                     end
                     tail_in[lv_e]     = t_ff;
                     nonempty_in[lv_e] = 1'b1;
                     if (rv_ff && (rt_ff == t_ff)) begin
                        rs_in = 1'b0;
                     end
                     resched_in = 1'b1;
                  end
               end
               ACT_REMOVE: begin
                  err = !ok_ff || !rd_ff.queued;
                  if (!err) begin
                     wen_in[SLOT_PREV]   = n_ok;
                     wad_in[SLOT_PREV]   = n_ix;
                     wlk_in[SLOT_PREV]   = p;
                     wen_in[SLOT_NEXT_A] = p_ok;
                     wad_in[SLOT_NEXT_A] = p_ix;
                     wlk_in[SLOT_NEXT_A] = n;
                     if (!n_ok) begin
                        tail_in[lv_e] = p_ix;
                     end
                     if (!p_ok) begin
                        head_in[lv_e] = n_ix;
                     end
                     if (!n_ok && !p_ok) begin
                        nonempty_in[lv_e] = 1'b0;
                     end
                     wen_in[SLOT_REC]  = 1'b1;
                     wrec_in.queued    = 1'b0;
                     wrec_in.level     = rd_ff.level;
                     wrec_in.prev_link = NO_LINK;
                  end
               end
               ACT_SCHEDULE: begin
                  err       = !ok_ff;
                  pvalid_in = rv_ff;
                  prev_in   = rv_ff ? rt_wide[TASK_ID_W-1:0] : '0;
                  if (!err) begin
                     if (n_ok) begin
                        head_in[lv_e]       = n_ix;
                        tail_in[lv_e]       = t_ff;
                        wen_in[SLOT_PREV]   = 1'b1;
                        wad_in[SLOT_PREV]   = n_ix;
                        wlk_in[SLOT_PREV]   = NO_LINK;
                        wen_in[SLOT_NEXT_A] = 1'b1;
                        wad_in[SLOT_NEXT_A] = tl;
                        wlk_in[SLOT_NEXT_A] = t_link;
                        wen_in[SLOT_REC]    = 1'b1;
                     end
                     rt_in      = t_ff;
                     rv_in      = 1'b1;
                     rs_in      = 1'b1;
                     resched_in = 1'b0;
                     chosen_in  = t_wide[TASK_ID_W-1:0];
                     cvalid_in  = 1'b1;
                     sw_in      = !rv_ff || (rt_ff != t_ff);
                  end
               end
               default: begin
                  ticks_in   = ticks_ff + TICK_W'(1);
                  resched_in = 1'b1;
                  cond       = rv_ff && rs_ff && rd_ff.queued;
                  if (cond) begin
                     rs_in = 1'b0;
                     if (n_ok) begin
                        wen_in[SLOT_PREV]   = 1'b1;
                        wad_in[SLOT_PREV]   = n_ix;
                        wlk_in[SLOT_PREV]   = p;
                        wen_in[SLOT_NEXT_A] = p_ok;
                        wad_in[SLOT_NEXT_A] = p_ix;
                        wlk_in[SLOT_NEXT_A] = n;
                        if (!p_ok) begin
                           head_in[lv_e] = n_ix;
                        end
                        wen_in[SLOT_NEXT_B] = 1'b1;
                        wad_in[SLOT_NEXT_B] = tl;
                        wlk_in[SLOT_NEXT_B] = t_link;
                        wen_in[SLOT_REC]    = 1'b1;
                        tail_in[lv_e]       = t_ff;
                     end
                  end
               end
            endcase
            err_in   = err;
            needs_in = resched_in;
            count_in = ticks_in;
            slot_in  = SLOT_PREV;
            state_in = err ? ST_IDLE : ST_WRITE;
         end
         ST_WRITE: begin
            slot_in = slot_ff + 2'd1;
            if (slot_ff == SLOT_REC) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         slot_ff      <= SLOT_PREV;
         nonempty_ff  <= '0;
         rt_ff        <= '0;
         rv_ff        <= 1'b0;
         rs_ff        <= 1'b0;
         ticks_ff     <= '0;
         resched_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         slot_ff      <= slot_in;
         nonempty_ff  <= nonempty_in;
         rt_ff        <= rt_in;
         rv_ff        <= rv_in;
         rs_ff        <= rs_in;
         ticks_ff     <= ticks_in;
         resched_ff   <= resched_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff   <= head_in;
      tail_ff   <= tail_in;
      act_ff    <= act_in;
      t_ff      <= t_in;
      lv_ff     <= lv_in;
      ok_ff     <= ok_in;
      wen_ff    <= wen_in;
      wad_ff    <= wad_in;
      wlk_ff    <= wlk_in;
      wrec_ff   <= wrec_in;
      chosen_ff <= chosen_in;
      cvalid_ff <= cvalid_in;
      prev_ff   <= prev_in;
      pvalid_ff <= pvalid_in;
      sw_ff     <= sw_in;
      needs_ff  <= needs_in;
      err_ff    <= err_in;
      count_ff  <= count_in;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff <= rec_mem[sel_t];
      end
      if (state_ff == ST_CLEAR) begin
         rec_mem[clr_ff].queued <= 1'b0;
      end else if ((state_ff == ST_WRITE) && wen_ff[slot_ff]) begin
         case (slot_ff)
            SLOT_PREV: begin
               rec_mem[wad_ff[SLOT_PREV]].prev_link <= wlk_ff[SLOT_PREV];
            end
            SLOT_NEXT_A: begin
               rec_mem[wad_ff[SLOT_NEXT_A]].next_link <= wlk_ff[SLOT_NEXT_A];
            end
            SLOT_NEXT_B: begin
               rec_mem[wad_ff[SLOT_NEXT_B]].next_link <= wlk_ff[SLOT_NEXT_B];
            end
            default: begin
               rec_mem[wad_ff[SLOT_REC]] <= wrec_ff;
            end
         endcase
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_chosen_task      = chosen_ff;
   assign rsp_chosen_valid     = cvalid_ff;
   assign rsp_previous_task    = prev_ff;
   assign rsp_previous_valid   = pvalid_ff;
   assign rsp_switch_needed    = sw_ff;
   assign rsp_needs_scheduling = needs_ff;
   assign rsp_error            = err_ff;
   assign rsp_tick_count       = count_ff;

endmodule

### src/prrs_checker.sv
`timescale 1ns / 1ps

module prrs_checker
   import prrs_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input logic                 rsp_valid,
   input logic [TASK_ID_W-1:0] rsp_chosen_task,
   input logic                 rsp_chosen_valid,
   input logic                 rsp_switch_needed,
   input logic                 rsp_needs_scheduling,
   input logic                 rsp_error
);

   logic accept;

   assign accept = start && !busy;

   // Every accepted word yields a result, marked by rsp_valid.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##2 rsp_valid)
      else $error("accepted word produced no result");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("block not busy after accepting a word");

   a_chosen_no_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_chosen_valid) |-> (!rsp_error && !rsp_needs_scheduling))
      else $error("successful schedule reported error or pending reschedule");

   a_no_choice_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_chosen_valid) |->
         (!rsp_switch_needed && (rsp_chosen_task == '0)))
      else $error("switch or task reported without a chosen task");

endmodule

bind priority_round_robin_scheduler prrs_checker u_prrs_checker (
   .clock                (clock),
   .reset                (reset),
   .start                (start),
   .busy                 (busy),
   .rsp_valid            (rsp_valid),
   .rsp_chosen_task      (rsp_chosen_task),
   .rsp_chosen_valid     (rsp_chosen_valid),
   .rsp_switch_needed    (rsp_switch_needed),
   .rsp_needs_scheduling (rsp_needs_scheduling),
   .rsp_error            (rsp_error)
);
